>>> rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths and defaults for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int FIELD_BITS        = 32;
	localparam int OPERAND_BITS_DEF  = 32;
	localparam int EXPONENT_BITS_DEF = 32;

endpackage

>>> rtl/core/mexp_cell.sv
// ----------------------------------------------------------------------------
// mexp_cell
// One step of interleaved modular multiplication: r = (2r + bit*a) mod m.
// ----------------------------------------------------------------------------
module mexp_cell import mexp_pkg::*; #(
	parameter int N   = OPERAND_BITS_DEF,
	parameter int BIT = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vld_in,
	input  logic [N-1:0] r_in,
	input  logic [N-1:0] a_in,
	input  logic [N-1:0] x_in,
	input  logic [N-1:0] m_in,
	output logic         vld_q,
	output logic [N-1:0] r_q,
	output logic [N-1:0] a_q,
	output logic [N-1:0] x_q,
	output logic [N-1:0] m_q
);

	logic [N+1:0] t0;
	logic [N+1:0] t1;
	logic [N+1:0] t2;
	logic [N+1:0] m_w;

	always_comb begin
		m_w = {2'b00, m_in};
		t0  = {1'b0, r_in, 1'b0} + (x_in[BIT] ? {2'b00, a_in} : '0);
		// r and a stay below m, so two subtracts bring the sum back in range
		t1  = (t0 >= m_w) ? t0 - m_w : t0;
		t2  = (t1 >= m_w) ? t1 - m_w : t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		r_q <= t2[N-1:0];
		a_q <= a_in;
		x_q <= x_in;
		m_q <= m_in;
	end

endmodule

>>> rtl/core/mexp_chain.sv
// ----------------------------------------------------------------------------
// mexp_chain
// Row of N cells computing a*x mod m, multiplier bits from the top down.
// ----------------------------------------------------------------------------
module mexp_chain import mexp_pkg::*; #(
	parameter int N = OPERAND_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] a,
	input  logic [N-1:0] x,
	input  logic [N-1:0] m,
	output logic         done,
	output logic [N-1:0] r
);

	logic         vld_w [0:N];
	logic [N-1:0] r_w   [0:N];
	logic [N-1:0] a_w   [0:N];
	logic [N-1:0] x_w   [0:N];
	logic [N-1:0] m_w   [0:N];

	assign vld_w[0] = start;
	assign r_w[0]   = '0;
	assign a_w[0]   = a;
	assign x_w[0]   = x;
	assign m_w[0]   = m;

	for (genvar k = 0; k < N; k++) begin : g_cell
		mexp_cell #(
			.N  (N),
			.BIT(N - 1 - k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.vld_in(vld_w[k]),
			.r_in  (r_w[k]),
			.a_in  (a_w[k]),
			.x_in  (x_w[k]),
			.m_in  (m_w[k]),
			.vld_q (vld_w[k+1]),
			.r_q   (r_w[k+1]),
			.a_q   (a_w[k+1]),
			.x_q   (x_w[k+1]),
			.m_q   (m_w[k+1])
		);
	end

	assign done = vld_w[N];
	assign r    = r_w[N];

endmodule

>>> rtl/core/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base^exponent mod modulus by square-and-multiply over a cell chain.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | fields
// in      | input     | in_valid/in_stall  | base, exponent, modulus
// out     | output    | out_valid/out_stall| power_mod, error_flag
//
// Each modular product passes through the OPERAND_BITS-cell chain. An item
// takes one reduction of the base, one squaring per exponent bit and one
// multiply per set exponent bit; a zero modulus goes straight to S_DONE.
// Reset clears the controller and output valid; no clearing pass.
// A result waits in the output register while the next item is taken.
module modular_exponentiation_top import mexp_pkg::*; #(
	parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
	parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FIELD_BITS-1:0] base,
	input  logic [FIELD_BITS-1:0] exponent,
	input  logic [FIELD_BITS-1:0] modulus,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FIELD_BITS-1:0] power_mod,
	output logic                  error_flag
);

	localparam int N  = OPERAND_BITS;
	localparam int EB = EXPONENT_BITS;
	localparam int CW = (EB > 1) ? $clog2(EB) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RED  = 5'b00010,
		S_SQR  = 5'b00100,
		S_MUL  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t          state_q;
	logic            wait_q;
	logic [N-1:0]    b_q;
	logic [N-1:0]    m_q;
	logic [N-1:0]    bred_q;
	logic [N-1:0]    acc_q;
	logic [EB-1:0]   e_q;
	logic [CW-1:0]   cnt_q;
	logic            err_q;
	logic [N-1:0]    res_q;
	logic            out_err_q;
	logic            out_vld_q;

	logic            start;
	logic [N-1:0]    ch_a;
	logic [N-1:0]    ch_x;
	logic            ch_done;
	logic [N-1:0]    ch_r;
	logic [EB-1:0]   e_in;
	logic [N-1:0]    m_in;
	logic [N-1:0]    one_m;
	logic            last_bit;
	logic            out_free;

	if (EB <= FIELD_BITS) begin : g_e_trunc
		assign e_in = exponent[EB-1:0];
	end else begin : g_e_ext
		assign e_in = EB'(exponent);
	end

	assign m_in     = modulus[N-1:0];
	assign one_m    = (m_in == N'(1)) ? '0 : N'(1);
	assign last_bit = (cnt_q == '0);
	assign out_free = !out_vld_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign start    = !wait_q && (state_q == S_RED || state_q == S_SQR || state_q == S_MUL);

	always_comb begin
		unique case (state_q)
			S_RED: begin
				ch_a = (m_q == N'(1)) ? '0 : N'(1);
				ch_x = b_q;
			end
			S_MUL: begin
				ch_a = bred_q;
				ch_x = acc_q;
			end
			default: begin
				ch_a = acc_q;
				ch_x = acc_q;
			end
		endcase
	end

	mexp_chain #(.N(N)) u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.a     (ch_a),
		.x     (ch_x),
		.m     (m_q),
		.done  (ch_done),
		.r     (ch_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wait_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			if (start) begin
				wait_q <= 1'b1;
			end else if (ch_done) begin
				wait_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (m_in == '0) ? S_DONE : S_RED;
					end
				end
				S_RED: begin
					if (ch_done) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (ch_done) begin
						priority if (e_q[EB-1]) state_q <= S_MUL;
						else if (last_bit)      state_q <= S_DONE;
						else                    state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (ch_done) begin
						state_q <= last_bit ? S_DONE : S_SQR;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			b_q   <= base[N-1:0];
			m_q   <= m_in;
			e_q   <= e_in;
			cnt_q <= CW'(EB - 1);
			acc_q <= one_m;
			err_q <= (m_in == '0);
		end
		if (ch_done) begin
			if (state_q == S_RED) begin
				bred_q <= ch_r;
			end else begin
				acc_q <= ch_r;
			end
			// advance to the next exponent bit once this bit is finished
			if ((state_q == S_SQR && !e_q[EB-1]) || state_q == S_MUL) begin
				e_q   <= e_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
		end
		if (state_q == S_DONE && out_free) begin
			res_q     <= err_q ? '0 : acc_q;
			out_err_q <= err_q;
		end
	end

	assign out_valid  = out_vld_q;
	assign power_mod  = FIELD_BITS'(res_q);
	assign error_flag = out_err_q;

`ifndef NO_ASSERTIONS
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		ch_done |-> wait_q)
		else $error("chain result without a pending product");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !wait_q && !ch_done)
		else $error("product launched while another is in flight");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_err_q |-> res_q == '0)
		else $error("error result carries a nonzero value");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> out_vld_q && state_q == S_IDLE)
		else $error("finished item not moved to output register");
`endif

endmodule
